### rtl/core/vucrp_pkg.sv
// ----------------------------------------------------------------------------
// vucrp_pkg
// Types, constants and helpers shared by the video unit register port.
// ----------------------------------------------------------------------------
package vucrp_pkg;

    localparam int NAMETABLE_BYTES = 4096;
    localparam int PATTERN_BYTES   = 8192;
    localparam int SPRITE_BYTES    = 256;
    localparam int PALETTE_BYTES   = 32;

    localparam int NT_AW  = $clog2(NAMETABLE_BYTES);
    localparam int PAT_AW = $clog2(PATTERN_BYTES);
    localparam int SPR_AW = $clog2(SPRITE_BYTES);
    localparam int PAL_AW = $clog2(PALETTE_BYTES);

    localparam int QUEUE_DEPTH = 3;
    localparam int Q_AW        = $clog2(QUEUE_DEPTH);
    localparam int Q_CW        = $clog2(QUEUE_DEPTH + 1);

    localparam int APB_AW = 3;

    localparam logic [15:0] VRAM_BUF_LIMIT   = 16'h3EFF;
    localparam logic [7:0]  PALETTE_PAGE     = 8'h3F;
    localparam logic [8:0]  STATUS_RACE_LINE = 9'd241;
    localparam logic [8:0]  STATUS_RACE_DOTS = 9'd2;
    localparam logic [8:0]  EVAL_LINE_END    = 9'd240;
    localparam logic [8:0]  EVAL_DOT_FIRST   = 9'd1;
    localparam logic [8:0]  EVAL_DOT_LAST    = 9'd64;
    localparam logic [7:0]  SPR_EVAL_BYTE    = 8'hFF;
    localparam logic [15:0] VINC_ROW         = 16'd32;
    localparam logic [15:0] VINC_COL         = 16'd1;
    localparam logic [2:0]  STATUS_KEEP_MASK = 3'b011;

    localparam logic [1:0] MIR_HORIZONTAL = 2'd0;
    localparam logic [1:0] MIR_VERTICAL   = 2'd1;

    localparam logic CFG_MIRRORING = 1'b0;

    typedef enum logic {
        OP_READ  = 1'b0,
        OP_WRITE = 1'b1
    } t_op;

    typedef enum logic [2:0] {
        REG_CTRL     = 3'd0,
        REG_MASK     = 3'd1,
        REG_STATUS   = 3'd2,
        REG_OAM_ADDR = 3'd3,
        REG_OAM_DATA = 3'd4,
        REG_SCROLL   = 3'd5,
        REG_ADDR     = 3'd6,
        REG_DATA     = 3'd7
    } t_reg_sel;

    typedef enum logic [1:0] {
        MSEL_SPR = 2'd0,
        MSEL_PAT = 2'd1,
        MSEL_NT  = 2'd2,
        MSEL_PAL = 2'd3
    } t_msel;

    typedef struct packed {
        logic       operation;
        logic [2:0] reg_select;
        logic [7:0] write_data;
        logic [8:0] scan_line;
        logic [8:0] scan_dot;
        logic [2:0] status_set;
        logic [2:0] status_clear;
    } t_in_item;

    typedef struct packed {
        logic [7:0]  read_data;
        logic [7:0]  control_value;
        logic [7:0]  mask_value;
        logic [15:0] vram_address;
        logic [14:0] temp_address;
        logic [2:0]  fine_scroll_x;
        logic [7:0]  sprite_address;
    } t_out_item;

    typedef struct packed {
        logic              we;
        t_msel             sel;
        logic [SPR_AW-1:0] spr_addr;
        logic [PAT_AW-1:0] pat_addr;
        logic [NT_AW-1:0]  nt_addr;
        logic [PAL_AW-1:0] pal_addr;
        logic [7:0]        wdata;
    } t_mem_req;

    typedef struct packed {
        logic [7:0] spr;
        logic [7:0] pat;
        logic [7:0] nt;
        logic [7:0] pal;
    } t_mem_rd;

    function automatic logic [7:0] pick_byte(t_mem_rd rd, t_msel sel);
        logic [7:0] b;
        case (sel)
            MSEL_SPR: b = rd.spr;
            MSEL_PAT: b = rd.pat;
            MSEL_NT:  b = rd.nt;
            MSEL_PAL: b = rd.pal;
            default:  b = rd.spr;
        endcase
        return b;
    endfunction

endpackage

### rtl/core/video_unit_cpu_register_port.sv
// ----------------------------------------------------------------------------
// video_unit_cpu_register_port
// CPU register port of a tile-based picture unit.
//
// The input channel takes one CPU access per item: a read or write of one of
// the eight registers, with the renderer's scanline, dot and status masks.
// The output channel returns one result item per access: the byte read (or
// the open bus latch on a write) and the control, mask, scroll and sprite
// address registers as they stand after the access.
// Each access issues its store read or write at the edge it is accepted; the
// result is registered ahead of the queue. Store read data is forwarded to
// the following access, so one item is accepted every cycle ready is high.
// A three-entry result queue decouples the channels: while the receiver
// stalls, items keep being accepted until the queue and the stage in front
// of it hold three results, then ready drops.
// After reset all registers are zero and a clearing pass writes zero into
// the sprite, pattern, nametable and palette stores, one address a cycle,
// up to the last pattern address; no item is accepted during the pass.
// The mirroring mode register lies at APB address 0 and can be written at
// any time the block is idle.
// ----------------------------------------------------------------------------
module video_unit_cpu_register_port (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_in_valid,
    output logic                           o_in_ready,
    input  vucrp_pkg::t_in_item            i_in_item,
    output logic                           o_out_valid,
    input  logic                           i_out_ready,
    output vucrp_pkg::t_out_item           o_out_item,
    input  logic                           psel,
    input  logic                           penable,
    input  logic                           pwrite,
    input  logic [vucrp_pkg::APB_AW-1:0]   paddr,
    input  logic [31:0]                    pwdata,
    output logic [31:0]                    prdata,
    output logic                           pready
);

    logic [1:0]                 r_mirroring;
    vucrp_pkg::t_mem_req        mem_req;
    vucrp_pkg::t_mem_rd         mem_rd;
    logic                       clr_busy;
    logic [vucrp_pkg::Q_CW-1:0] q_count;
    logic                       res_valid;
    vucrp_pkg::t_out_item       res_item;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mirroring <= vucrp_pkg::MIR_HORIZONTAL;
        end else if (psel && penable && pwrite && pready &&
                     paddr[2] == vucrp_pkg::CFG_MIRRORING) begin
            r_mirroring <= pwdata[1:0];
        end
    end

    assign prdata = (paddr[2] == vucrp_pkg::CFG_MIRRORING) ? {30'd0, r_mirroring} : 32'd0;

    vucrp_mem u_mem (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_req      (mem_req),
        .o_rd       (mem_rd),
        .o_clr_busy (clr_busy)
    );

    vucrp_core u_core (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_mirroring (r_mirroring),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .i_clr_busy  (clr_busy),
        .i_q_count   (q_count),
        .o_mem_req   (mem_req),
        .i_mem_rd    (mem_rd),
        .o_res_valid (res_valid),
        .o_res_item  (res_item)
    );

    vucrp_outq u_outq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (res_valid),
        .i_push_item (res_item),
        .o_valid     (o_out_valid),
        .i_ready     (i_out_ready),
        .o_item      (o_out_item),
        .o_count     (q_count)
    );

endmodule

### rtl/core/vucrp_ram.sv
// ----------------------------------------------------------------------------
// vucrp_ram
// Generic single-port synchronous RAM with a registered read.
// ----------------------------------------------------------------------------
module vucrp_ram #(
    parameter int P_WIDTH = 8,
    parameter int P_DEPTH = 256
) (
    input  logic                       i_clk,
    input  logic                       i_we,
    input  logic [$clog2(P_DEPTH)-1:0] i_addr,
    input  logic [P_WIDTH-1:0]         i_wdata,
    output logic [P_WIDTH-1:0]         o_rdata
);

    logic [P_WIDTH-1:0] r_mem [P_DEPTH];
    logic [P_WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/core/vucrp_mem.sv
// ----------------------------------------------------------------------------
// vucrp_mem
// Sprite, pattern, nametable and palette stores with the clearing pass
// that zeroes all of them after reset.
// ----------------------------------------------------------------------------
module vucrp_mem (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  vucrp_pkg::t_mem_req i_req,
    output vucrp_pkg::t_mem_rd  o_rd,
    output logic               o_clr_busy
);

    logic                         r_clr_busy;
    logic [vucrp_pkg::PAT_AW-1:0] r_clr_addr;

    logic                         spr_we, pat_we, nt_we, pal_we;
    logic [vucrp_pkg::SPR_AW-1:0] spr_addr;
    logic [vucrp_pkg::PAT_AW-1:0] pat_addr;
    logic [vucrp_pkg::NT_AW-1:0]  nt_addr;
    logic [vucrp_pkg::PAL_AW-1:0] pal_addr;
    logic [7:0]                   wdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_comb begin
        spr_we   = r_clr_busy | (i_req.we && i_req.sel == vucrp_pkg::MSEL_SPR);
        pat_we   = r_clr_busy | (i_req.we && i_req.sel == vucrp_pkg::MSEL_PAT);
        nt_we    = r_clr_busy | (i_req.we && i_req.sel == vucrp_pkg::MSEL_NT);
        pal_we   = r_clr_busy | (i_req.we && i_req.sel == vucrp_pkg::MSEL_PAL);
        spr_addr = r_clr_busy ? r_clr_addr[vucrp_pkg::SPR_AW-1:0] : i_req.spr_addr;
        pat_addr = r_clr_busy ? r_clr_addr : i_req.pat_addr;
        nt_addr  = r_clr_busy ? r_clr_addr[vucrp_pkg::NT_AW-1:0] : i_req.nt_addr;
        pal_addr = r_clr_busy ? r_clr_addr[vucrp_pkg::PAL_AW-1:0] : i_req.pal_addr;
        wdata    = r_clr_busy ? 8'h00 : i_req.wdata;
    end

    vucrp_ram #(.P_WIDTH(8), .P_DEPTH(vucrp_pkg::SPRITE_BYTES)) u_spr (
        .i_clk(i_clk), .i_we(spr_we), .i_addr(spr_addr), .i_wdata(wdata), .o_rdata(o_rd.spr)
    );

    vucrp_ram #(.P_WIDTH(8), .P_DEPTH(vucrp_pkg::PATTERN_BYTES)) u_pat (
        .i_clk(i_clk), .i_we(pat_we), .i_addr(pat_addr), .i_wdata(wdata), .o_rdata(o_rd.pat)
    );

    vucrp_ram #(.P_WIDTH(8), .P_DEPTH(vucrp_pkg::NAMETABLE_BYTES)) u_nt (
        .i_clk(i_clk), .i_we(nt_we), .i_addr(nt_addr), .i_wdata(wdata), .o_rdata(o_rd.nt)
    );

    vucrp_ram #(.P_WIDTH(8), .P_DEPTH(vucrp_pkg::PALETTE_BYTES)) u_pal (
        .i_clk(i_clk), .i_we(pal_we), .i_addr(pal_addr), .i_wdata(wdata), .o_rdata(o_rd.pal)
    );

    assign o_clr_busy = r_clr_busy;

endmodule

### rtl/core/vucrp_core.sv
// ----------------------------------------------------------------------------
// vucrp_core
// Register file and access decode. Issues store accesses at acceptance and
// resolves store read data in the next cycle, forwarding it to the next item.
// ----------------------------------------------------------------------------
module vucrp_core (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic [1:0]                    i_mirroring,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  vucrp_pkg::t_in_item           i_in_item,
    input  logic                          i_clr_busy,
    input  logic [vucrp_pkg::Q_CW-1:0]    i_q_count,
    output vucrp_pkg::t_mem_req           o_mem_req,
    input  vucrp_pkg::t_mem_rd            i_mem_rd,
    output logic                          o_res_valid,
    output vucrp_pkg::t_out_item          o_res_item
);

    logic [2:0]       r_status, n_status;
    logic [7:0]       r_open_bus, n_open_bus;
    logic             r_ob_pend, n_ob_pend;
    vucrp_pkg::t_msel r_ob_msel, n_ob_msel;
    logic [7:0]       r_read_buffer, n_read_buffer;
    logic             r_rb_pend, n_rb_pend;
    vucrp_pkg::t_msel r_rb_msel, n_rb_msel;
    logic [15:0]      r_v, n_v;
    logic [14:0]      r_t, n_t;
    logic [2:0]       r_fine_x, n_fine_x;
    logic             r_toggle, n_toggle;
    logic [7:0]       r_ctrl, n_ctrl;
    logic [7:0]       r_mask, n_mask;
    logic [7:0]       r_spr_addr, n_spr_addr;

    logic                 r_s1_valid;
    logic                 r_s1_pend, n_s1_pend;
    vucrp_pkg::t_msel     r_s1_msel, n_s1_msel;
    vucrp_pkg::t_out_item r_s1_item, n_s1_item;

    logic             accept;
    logic [7:0]       ob_eff, rb_eff;
    logic             v_is_pat, v_is_pal, v_is_nt, v_buffered;
    vucrp_pkg::t_msel v_msel;
    logic [11:0]      nt_full;
    logic [4:0]       pal_raw;
    logic [15:0]      v_step;
    logic [2:0]       status_eff;
    logic [7:0]       ret;
    logic             ret_pend;
    vucrp_pkg::t_msel ret_msel;
    logic             in_eval;
    logic             in_race;
    logic [7:0]       d;

    assign ob_eff = r_ob_pend ? vucrp_pkg::pick_byte(i_mem_rd, r_ob_msel) : r_open_bus;
    assign rb_eff = r_rb_pend ? vucrp_pkg::pick_byte(i_mem_rd, r_rb_msel) : r_read_buffer;

    assign o_in_ready = !i_clr_busy &&
        (({1'b0, i_q_count} + {{vucrp_pkg::Q_CW{1'b0}}, r_s1_valid}) <
         (vucrp_pkg::Q_CW + 1)'(vucrp_pkg::QUEUE_DEPTH));
    assign accept = i_in_valid && o_in_ready;
    assign d      = i_in_item.write_data;

    always_comb begin
        v_is_pat   = (r_v[15:13] == 3'b000);
        v_is_pal   = (r_v[15:8] == vucrp_pkg::PALETTE_PAGE);
        v_is_nt    = (r_v[15:13] == 3'b001) ||
                     (r_v[15:12] == 4'h3 && !v_is_pal);
        v_buffered = (r_v <= vucrp_pkg::VRAM_BUF_LIMIT);
        v_msel     = v_is_pat ? vucrp_pkg::MSEL_PAT :
                     (v_is_pal ? vucrp_pkg::MSEL_PAL : vucrp_pkg::MSEL_NT);
        case (i_mirroring)
            vucrp_pkg::MIR_HORIZONTAL: nt_full = {r_v[11], 1'b0, r_v[9:0]};
            vucrp_pkg::MIR_VERTICAL:   nt_full = {1'b0, r_v[10:0]};
            default:                   nt_full = r_v[11:0];
        endcase
        pal_raw = r_v[4:0];
        v_step  = r_ctrl[2] ? vucrp_pkg::VINC_ROW : vucrp_pkg::VINC_COL;
        in_eval = (i_in_item.scan_line < vucrp_pkg::EVAL_LINE_END) &&
                  (i_in_item.scan_dot >= vucrp_pkg::EVAL_DOT_FIRST) &&
                  (i_in_item.scan_dot <= vucrp_pkg::EVAL_DOT_LAST);
        in_race = (i_in_item.scan_line == vucrp_pkg::STATUS_RACE_LINE) &&
                  (i_in_item.scan_dot < vucrp_pkg::STATUS_RACE_DOTS);
    end

    always_comb begin
        o_mem_req.spr_addr = r_spr_addr;
        o_mem_req.pat_addr = r_v[vucrp_pkg::PAT_AW-1:0];
        o_mem_req.nt_addr  = nt_full[vucrp_pkg::NT_AW-1:0];
        o_mem_req.pal_addr = {pal_raw[4] | (pal_raw[1:0] == 2'b00), pal_raw[3:0]};
        o_mem_req.wdata    = d;
        if (vucrp_pkg::t_reg_sel'(i_in_item.reg_select) == vucrp_pkg::REG_OAM_DATA) begin
            o_mem_req.sel = vucrp_pkg::MSEL_SPR;
            o_mem_req.we  = accept && i_in_item.operation == vucrp_pkg::OP_WRITE;
        end else begin
            o_mem_req.sel = v_msel;
            o_mem_req.we  = accept && i_in_item.operation == vucrp_pkg::OP_WRITE &&
                vucrp_pkg::t_reg_sel'(i_in_item.reg_select) == vucrp_pkg::REG_DATA &&
                (v_is_pat || v_is_nt || v_is_pal);
        end
    end

    always_comb begin
        n_status      = r_status;
        n_open_bus    = ob_eff;
        n_ob_pend     = 1'b0;
        n_ob_msel     = r_ob_msel;
        n_read_buffer = rb_eff;
        n_rb_pend     = 1'b0;
        n_rb_msel     = r_rb_msel;
        n_v           = r_v;
        n_t           = r_t;
        n_fine_x      = r_fine_x;
        n_toggle      = r_toggle;
        n_ctrl        = r_ctrl;
        n_mask        = r_mask;
        n_spr_addr    = r_spr_addr;
        status_eff    = (r_status & ~i_in_item.status_clear) | i_in_item.status_set;
        ret           = ob_eff;
        ret_pend      = 1'b0;
        ret_msel      = vucrp_pkg::MSEL_SPR;

        if (accept) begin
            n_status = status_eff;
            if (i_in_item.operation == vucrp_pkg::OP_READ) begin
                case (vucrp_pkg::t_reg_sel'(i_in_item.reg_select))
                    vucrp_pkg::REG_STATUS: begin
                        ret      = {status_eff, ob_eff[4:0]};
                        if (in_race) begin
                            ret[7] = 1'b0;
                        end
                        n_status = status_eff & vucrp_pkg::STATUS_KEEP_MASK;
                        n_toggle = 1'b0;
                    end
                    vucrp_pkg::REG_OAM_DATA: begin
                        if (in_eval) begin
                            ret = vucrp_pkg::SPR_EVAL_BYTE;
                        end else begin
                            ret_pend = 1'b1;
                            ret_msel = vucrp_pkg::MSEL_SPR;
                        end
                    end
                    vucrp_pkg::REG_DATA: begin
                        if (v_buffered) begin
                            ret       = rb_eff;
                            n_rb_pend = 1'b1;
                            n_rb_msel = v_msel;
                        end else if (v_is_pal) begin
                            ret_pend = 1'b1;
                            ret_msel = vucrp_pkg::MSEL_PAL;
                        end else begin
                            ret = 8'h00;
                        end
                        n_v = r_v + v_step;
                    end
                    default: begin
                    end
                endcase
                n_open_bus = ret;
                n_ob_pend  = ret_pend;
                n_ob_msel  = ret_msel;
            end else begin
                case (vucrp_pkg::t_reg_sel'(i_in_item.reg_select))
                    vucrp_pkg::REG_CTRL: begin
                        n_ctrl = d;
                        n_t    = {r_t[14:12], d[1:0], r_t[9:0]};
                    end
                    vucrp_pkg::REG_MASK: begin
                        n_mask = d;
                    end
                    vucrp_pkg::REG_OAM_ADDR: begin
                        n_spr_addr = d;
                    end
                    vucrp_pkg::REG_OAM_DATA: begin
                        n_spr_addr = r_spr_addr + 8'd1;
                    end
                    vucrp_pkg::REG_SCROLL: begin
                        if (!r_toggle) begin
                            n_t      = {r_t[14:5], d[7:3]};
                            n_fine_x = d[2:0];
                        end else begin
                            n_t = {d[2:0], r_t[11:10], d[7:3], r_t[4:0]};
                        end
                        n_toggle = !r_toggle;
                    end
                    vucrp_pkg::REG_ADDR: begin
                        if (!r_toggle) begin
                            n_t = {1'b0, d[5:0], r_t[7:0]};
                        end else begin
                            n_t = {r_t[14:8], d};
                            n_v = {1'b0, r_t[14:8], d};
                        end
                        n_toggle = !r_toggle;
                    end
                    vucrp_pkg::REG_DATA: begin
                        n_v = r_v + v_step;
                    end
                    default: begin
                    end
                endcase
            end
        end

        n_s1_pend                = ret_pend;
        n_s1_msel                = ret_msel;
        n_s1_item.read_data      = ret;
        n_s1_item.control_value  = n_ctrl;
        n_s1_item.mask_value     = n_mask;
        n_s1_item.vram_address   = n_v;
        n_s1_item.temp_address   = n_t;
        n_s1_item.fine_scroll_x  = n_fine_x;
        n_s1_item.sprite_address = n_spr_addr;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_status      <= '0;
            r_open_bus    <= '0;
            r_ob_pend     <= 1'b0;
            r_ob_msel     <= vucrp_pkg::MSEL_SPR;
            r_read_buffer <= '0;
            r_rb_pend     <= 1'b0;
            r_rb_msel     <= vucrp_pkg::MSEL_PAT;
            r_v           <= '0;
            r_t           <= '0;
            r_fine_x      <= '0;
            r_toggle      <= 1'b0;
            r_ctrl        <= '0;
            r_mask        <= '0;
            r_spr_addr    <= '0;
            r_s1_valid    <= 1'b0;
        end else begin
            r_status      <= n_status;
            r_open_bus    <= n_open_bus;
            r_ob_pend     <= n_ob_pend;
            r_ob_msel     <= n_ob_msel;
            r_read_buffer <= n_read_buffer;
            r_rb_pend     <= n_rb_pend;
            r_rb_msel     <= n_rb_msel;
            r_v           <= n_v;
            r_t           <= n_t;
            r_fine_x      <= n_fine_x;
            r_toggle      <= n_toggle;
            r_ctrl        <= n_ctrl;
            r_mask        <= n_mask;
            r_spr_addr    <= n_spr_addr;
            r_s1_valid    <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_pend <= n_s1_pend;
            r_s1_msel <= n_s1_msel;
            r_s1_item <= n_s1_item;
        end
    end

    always_comb begin
        o_res_valid = r_s1_valid;
        o_res_item  = r_s1_item;
        if (r_s1_pend) begin
            o_res_item.read_data = vucrp_pkg::pick_byte(i_mem_rd, r_s1_msel);
        end
    end

endmodule

### rtl/core/vucrp_outq.sv
// ----------------------------------------------------------------------------
// vucrp_outq
// Small result queue in front of the output channel.
// ----------------------------------------------------------------------------
module vucrp_outq (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  vucrp_pkg::t_out_item       i_push_item,
    output logic                       o_valid,
    input  logic                       i_ready,
    output vucrp_pkg::t_out_item       o_item,
    output logic [vucrp_pkg::Q_CW-1:0] o_count
);

    vucrp_pkg::t_out_item r_entry [vucrp_pkg::QUEUE_DEPTH];
    logic [vucrp_pkg::Q_AW-1:0] r_wr_ptr, n_wr_ptr;
    logic [vucrp_pkg::Q_AW-1:0] r_rd_ptr, n_rd_ptr;
    logic [vucrp_pkg::Q_CW-1:0] r_count, n_count;
    logic                       pop;

    assign pop     = o_valid && i_ready;
    assign o_valid = (r_count != '0);
    assign o_item  = r_entry[r_rd_ptr];
    assign o_count = r_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == vucrp_pkg::Q_AW'(vucrp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_wr_ptr + 1'b1;
        end
        if (pop) begin
            n_rd_ptr = (r_rd_ptr == vucrp_pkg::Q_AW'(vucrp_pkg::QUEUE_DEPTH - 1)) ?
                       '0 : r_rd_ptr + 1'b1;
        end
        n_count = r_count + {{(vucrp_pkg::Q_CW-1){1'b0}}, i_push}
                          - {{(vucrp_pkg::Q_CW-1){1'b0}}, pop};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_entry[r_wr_ptr] <= i_push_item;
        end
    end

endmodule

### rtl/core/vucrp_checker.sv
// ----------------------------------------------------------------------------
// vucrp_checker
// Port-level checks for the video unit register port.
// ----------------------------------------------------------------------------
module vucrp_checker (
    input logic                 i_clk,
    input logic                 i_rst_n,
    input logic                 i_in_valid,
    input logic                 o_in_ready,
    input logic                 o_out_valid,
    input logic                 i_out_ready,
    input vucrp_pkg::t_out_item o_out_item,
    input logic                 psel,
    input logic                 penable,
    input logic                 pready
);

    // A result that waits must hold steady.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> (o_out_valid && $stable(o_out_item)))
        else $error("result item changed or dropped while stalled");

    // Every accepted item must be followed by a valid result at the output.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |-> ##2 o_out_valid)
        else $error("accepted item produced no result");

    // The stores are being cleared right after reset, so no item is taken.
    a_clear_after_reset: assert property (@(posedge i_clk)
        $rose(i_rst_n) |-> !o_in_ready)
        else $error("item accepted during the clearing pass");

    // The configuration port never inserts wait states.
    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (psel && penable) |-> pready)
        else $error("configuration access stalled");

endmodule

bind video_unit_cpu_register_port vucrp_checker u_vucrp_checker (.*);

### tb/sv/tb_video_unit_cpu_register_port.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_video_unit_cpu_register_port
// Self-checking bench for the CPU register port of the video unit.
// A model inside the bench keeps its own copy of the registers, the scroll
// latches and the video stores. It predicts the reply to every accepted
// access, and each reply is checked field by field, in order. The stimulus
// is a short directed list followed by random register sequences, run under
// every mirroring mode. Both channels idle and stall at random, bar one phase.
// ----------------------------------------------------------------------------
module tb_video_unit_cpu_register_port;

    localparam int STALL_LIMIT     = 50000;
    localparam int ITEMS_PER_PHASE = 350;
    localparam int PHASES          = 5;
    localparam int IDLE_PCT        = 18;
    localparam int HOLD_AT         = 600;
    localparam int HOLD_LEN        = 400;
    localparam int DRAIN_CYCLES    = 4;
    localparam int END_CYCLES      = 8;

    localparam logic [1:0] MIR_FOUR_SCREEN     = 2'd2;
    localparam logic [1:0] MIR_FOUR_SCREEN_ALT = 2'd3;

    localparam int NT_BASE    = vucrp_pkg::PATTERN_BYTES;
    localparam int PAL_BASE   = vucrp_pkg::PATTERN_BYTES + vucrp_pkg::NAMETABLE_BYTES;
    localparam int VRAM_CELLS = PAL_BASE + vucrp_pkg::PALETTE_BYTES;

    logic                          clk      = 1'b0;
    logic                          rst_n    = 1'b0;
    logic                          in_valid = 1'b0;
    logic                          in_ready;
    vucrp_pkg::t_in_item           in_item  = '0;
    logic                          out_valid;
    logic                          out_ready = 1'b0;
    vucrp_pkg::t_out_item          out_item;
    logic                          psel     = 1'b0;
    logic                          penable  = 1'b0;
    logic                          pwrite   = 1'b0;
    logic [vucrp_pkg::APB_AW-1:0]  paddr    = '0;
    logic [31:0]                   pwdata   = '0;
    logic [31:0]                   prdata;
    logic                          pready;

    vucrp_pkg::t_in_item           access_queue[$];
    vucrp_pkg::t_out_item          reply_queue[$];
    int                            queued_total  = 0;
    int                            replies_taken = 0;
    int                            mismatches    = 0;
    int                            stall_cycles  = 0;
    int                            send_idle_pct = IDLE_PCT;
    int                            recv_idle_pct = IDLE_PCT;
    int                            hold_left     = 0;
    logic                          hold_done     = 1'b0;

    logic [2:0]          sh_status   = '0;
    logic [7:0]          sh_open_bus = '0;
    logic [7:0]          sh_read_buf = '0;
    logic [15:0]         sh_v        = '0;
    logic [14:0]         sh_t        = '0;
    logic [2:0]          sh_fine_x   = '0;
    logic                sh_toggle   = 1'b0;
    logic [7:0]          sh_ctrl     = '0;
    logic [7:0]          sh_mask     = '0;
    logic [7:0]          sh_oam_addr = '0;
    logic [1:0]          sh_mirror   = vucrp_pkg::MIR_HORIZONTAL;
    logic [7:0]          oam_image  [vucrp_pkg::SPRITE_BYTES];
    logic [7:0]          vram_image [VRAM_CELLS];

    video_unit_cpu_register_port DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_ready  (in_ready),
        .i_in_item   (in_item),
        .o_out_valid (out_valid),
        .i_out_ready (out_ready),
        .o_out_item  (out_item),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    always begin
        #6 clk = ~clk;
    end

    // Index into vram_image for a video address, or -1 above the palette page.
    function automatic int vram_slot(logic [15:0] a);
        int n;
        int idx;
        idx = -1;
        n   = a;
        if (a <= 16'h1FFF) begin
            idx = n % vucrp_pkg::PATTERN_BYTES;
        end else if (a <= vucrp_pkg::VRAM_BUF_LIMIT) begin
            if (n >= 'h3000) begin
                n = n - 'h1000;
            end
            if (sh_mirror == vucrp_pkg::MIR_HORIZONTAL) begin
                idx = (n >= 'h2800) ? ('h0800 + n % 'h0400) : (n % 'h0400);
            end else if (sh_mirror == vucrp_pkg::MIR_VERTICAL) begin
                idx = n % 'h0800;
            end else begin
                idx = n - 'h2000;
            end
            idx = NT_BASE + idx % vucrp_pkg::NAMETABLE_BYTES;
        end else if (a[15:8] == vucrp_pkg::PALETTE_PAGE) begin
            idx = n % vucrp_pkg::PALETTE_BYTES;
            if (idx % 4 == 0) begin
                idx = idx | 'h10;
            end
            idx = PAL_BASE + idx;
        end
        return idx;
    endfunction

    task automatic emulate_access(vucrp_pkg::t_in_item it);
        logic [7:0]           ret;
        logic [7:0]           d;
        int                   slot;
        vucrp_pkg::t_out_item r;
        d         = it.write_data;
        sh_status = (sh_status & ~it.status_clear) | it.status_set;
        ret       = sh_open_bus;
        if (it.operation == vucrp_pkg::OP_READ) begin
            case (vucrp_pkg::t_reg_sel'(it.reg_select))
                vucrp_pkg::REG_STATUS: begin
                    ret       = {sh_status, sh_open_bus[4:0]};
                    sh_status = sh_status & vucrp_pkg::STATUS_KEEP_MASK;
                    sh_toggle = 1'b0;
                    if (it.scan_line == vucrp_pkg::STATUS_RACE_LINE &&
                            it.scan_dot < vucrp_pkg::STATUS_RACE_DOTS) begin
                        ret[7] = 1'b0;
                    end
                end
                vucrp_pkg::REG_OAM_DATA: begin
                    if (it.scan_line < vucrp_pkg::EVAL_LINE_END &&
                            it.scan_dot >= vucrp_pkg::EVAL_DOT_FIRST &&
                            it.scan_dot <= vucrp_pkg::EVAL_DOT_LAST) begin
                        ret = vucrp_pkg::SPR_EVAL_BYTE;
                    end else begin
                        ret = oam_image[sh_oam_addr];
                    end
                end
                vucrp_pkg::REG_DATA: begin
                    slot = vram_slot(sh_v);
                    if (sh_v <= vucrp_pkg::VRAM_BUF_LIMIT) begin
                        ret         = sh_read_buf;
                        sh_read_buf = vram_image[slot];
                    end else begin
                        ret = (slot < 0) ? 8'h00 : vram_image[slot];
                    end
                    sh_v = sh_v + (sh_ctrl[2] ? vucrp_pkg::VINC_ROW : vucrp_pkg::VINC_COL);
                end
                default: ;
            endcase
            sh_open_bus = ret;
        end else begin
            case (vucrp_pkg::t_reg_sel'(it.reg_select))
                vucrp_pkg::REG_CTRL: begin
                    sh_ctrl       = d;
                    sh_t[11:10]   = d[1:0];
                end
                vucrp_pkg::REG_MASK: begin
                    sh_mask = d;
                end
                vucrp_pkg::REG_OAM_ADDR: begin
                    sh_oam_addr = d;
                end
                vucrp_pkg::REG_OAM_DATA: begin
                    oam_image[sh_oam_addr] = d;
                    sh_oam_addr            = sh_oam_addr + 8'd1;
                end
                vucrp_pkg::REG_SCROLL: begin
                    if (!sh_toggle) begin
                        sh_t[4:0] = d[7:3];
                        sh_fine_x = d[2:0];
                    end else begin
                        sh_t[14:12] = d[2:0];
                        sh_t[9:5]   = d[7:3];
                    end
                    sh_toggle = ~sh_toggle;
                end
                vucrp_pkg::REG_ADDR: begin
                    if (!sh_toggle) begin
                        sh_t[14]   = 1'b0;
                        sh_t[13:8] = d[5:0];
                    end else begin
                        sh_t[7:0] = d;
                        sh_v      = {1'b0, sh_t};
                    end
                    sh_toggle = ~sh_toggle;
                end
                vucrp_pkg::REG_DATA: begin
                    slot = vram_slot(sh_v);
                    if (slot >= 0) begin
                        vram_image[slot] = d;
                    end
                    sh_v = sh_v + (sh_ctrl[2] ? vucrp_pkg::VINC_ROW : vucrp_pkg::VINC_COL);
                end
                default: ;
            endcase
            ret = sh_open_bus;
        end
        r.read_data      = ret;
        r.control_value  = sh_ctrl;
        r.mask_value     = sh_mask;
        r.vram_address   = sh_v;
        r.temp_address   = sh_t;
        r.fine_scroll_x  = sh_fine_x;
        r.sprite_address = sh_oam_addr;
        reply_queue.push_back(r);
    endtask

    task automatic report_mismatch(string what);
        $display("ERROR reply %0d: %s", replies_taken, what);
        mismatches++;
    endtask

    task automatic compare_field(string name, logic [15:0] got, logic [15:0] want);
        if (got !== want) begin
            report_mismatch($sformatf("%s is %h, expected %h", name, got, want));
        end
    endtask

    task automatic queue_at(vucrp_pkg::t_op op, vucrp_pkg::t_reg_sel rs, logic [7:0] d,
                            logic [8:0] line, logic [8:0] dot, logic [2:0] set,
                            logic [2:0] clr);
        vucrp_pkg::t_in_item it;
        it.operation    = op;
        it.reg_select   = rs;
        it.write_data   = d;
        it.scan_line    = line;
        it.scan_dot     = dot;
        it.status_set   = set;
        it.status_clear = clr;
        access_queue.push_back(it);
        queued_total++;
    endtask

    task automatic queue_access(vucrp_pkg::t_op op, vucrp_pkg::t_reg_sel rs, logic [7:0] d);
        logic [8:0] line;
        logic [8:0] dot;
        logic [2:0] set;
        logic [2:0] clr;
        line = 9'($urandom_range(0, 261));
        dot  = 9'($urandom_range(0, 340));
        if ($urandom_range(0, 7) == 0) begin
            line = vucrp_pkg::STATUS_RACE_LINE;
            dot  = 9'($urandom_range(0, 2));
        end
        set = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
        clr = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'd0;
        queue_at(op, rs, d, line, dot, set, clr);
    endtask

    task automatic queue_random_burst();
        int         n;
        logic [7:0] hi;
        logic [7:0] lo;
        logic [7:0] oam_start;
        n  = $urandom_range(1, 6);
        lo = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 7));
        case ($urandom_range(0, 4))
            0:       hi = 8'($urandom_range(8'h00, 8'h1F));
            1, 2:    hi = 8'($urandom_range(8'h20, 8'h2F));
            3:       hi = vucrp_pkg::PALETTE_PAGE;
            default: hi = 8'($urandom);
        endcase
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5: begin
                if ($urandom_range(0, 3) == 0) begin
                    queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_CTRL, 8'($urandom));
                end
                if ($urandom_range(0, 7) != 0) begin
                    queue_access(vucrp_pkg::OP_READ, vucrp_pkg::REG_STATUS, 8'($urandom));
                end
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR, hi);
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR, lo);
                if ($urandom_range(0, 1) == 0) begin
                    for (int k = 0; k < n; k++) begin
                        queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_DATA, 8'($urandom));
                    end
                    if (hi[7:4] == 4'h2) begin
                        hi = hi ^ {3'b000, 1'($urandom), 2'($urandom), 2'b00};
                    end
                    queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR, hi);
                    queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR, lo);
                end
                for (int k = 0; k <= n; k++) begin
                    queue_access(vucrp_pkg::OP_READ, vucrp_pkg::REG_DATA, 8'($urandom));
                end
            end
            6: begin
                queue_access(vucrp_pkg::OP_READ, vucrp_pkg::REG_STATUS, 8'($urandom));
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom));
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_SCROLL, 8'($urandom));
            end
            7: begin
                oam_start = 8'($urandom);
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_ADDR, oam_start);
                for (int k = 0; k < n; k++) begin
                    queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_DATA, 8'($urandom));
                end
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_ADDR, oam_start);
                for (int k = 0; k < n; k++) begin
                    queue_access(vucrp_pkg::OP_READ, vucrp_pkg::REG_OAM_DATA, 8'($urandom));
                end
            end
            8: begin
                queue_access(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_MASK, 8'($urandom));
                queue_access(vucrp_pkg::OP_READ,
                             vucrp_pkg::t_reg_sel'($urandom_range(0, 7)), 8'($urandom));
            end
            default: begin
                for (int k = 0; k < n; k++) begin
                    queue_access(vucrp_pkg::t_op'($urandom_range(0, 1)),
                                 vucrp_pkg::t_reg_sel'($urandom_range(0, 7)),
                                 8'($urandom));
                end
            end
        endcase
    endtask

    task automatic wait_for_drain();
        while (access_queue.size() != 0 || in_valid || reply_queue.size() != 0) begin
            @(posedge clk);
        end
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_mirroring(logic [1:0] mode);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {vucrp_pkg::CFG_MIRRORING, 2'b00};
        pwdata  <= {30'd0, mode};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        sh_mirror = mode;
    endtask

    always @(posedge clk) begin
        if (!rst_n) begin
            in_valid <= 1'b0;
        end else begin
            if (in_valid && in_ready) begin
                emulate_access(in_item);
            end
            if (!in_valid || in_ready) begin
                if (access_queue.size() != 0 && $urandom_range(0, 99) >= send_idle_pct) begin
                    in_item  <= access_queue.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge clk) begin : reply_monitor
        vucrp_pkg::t_out_item want;
        if (!rst_n) begin
            out_ready <= 1'b0;
        end else begin
            if (out_valid && out_ready) begin
                if (reply_queue.size() == 0) begin
                    report_mismatch("reply with no access outstanding");
                end else begin
                    want = reply_queue.pop_front();
                    compare_field("read_data", out_item.read_data, want.read_data);
                    compare_field("control_value", out_item.control_value, want.control_value);
                    compare_field("mask_value", out_item.mask_value, want.mask_value);
                    compare_field("vram_address", out_item.vram_address, want.vram_address);
                    compare_field("temp_address", out_item.temp_address, want.temp_address);
                    compare_field("fine_scroll_x", out_item.fine_scroll_x, want.fine_scroll_x);
                    compare_field("sprite_address", out_item.sprite_address,
                                  want.sprite_address);
                end
                replies_taken <= replies_taken + 1;
            end
            if (hold_left != 0) begin
                hold_left <= hold_left - 1;
                out_ready <= 1'b0;
            end else if (!hold_done && replies_taken >= HOLD_AT) begin
                hold_left <= HOLD_LEN;
                hold_done <= 1'b1;
                out_ready <= 1'b0;
            end else begin
                out_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
            end
        end
    end

    always @(posedge clk) begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= STALL_LIMIT) begin
            $display("Verification failed");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        logic [1:0] mode;
        foreach (vram_image[k]) vram_image[k] = 8'h00;
        foreach (oam_image[k]) oam_image[k] = 8'h00;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;

        for (int p = 0; p < PHASES; p++) begin
            wait_for_drain();
            case (p)
                0, 4:    mode = vucrp_pkg::MIR_HORIZONTAL;
                1:       mode = vucrp_pkg::MIR_VERTICAL;
                2:       mode = MIR_FOUR_SCREEN_ALT;
                default: mode = MIR_FOUR_SCREEN;
            endcase
            write_mirroring(mode);
            send_idle_pct = (p == 2) ? 0 : IDLE_PCT;
            recv_idle_pct = (p == 2) ? 0 : IDLE_PCT;

            if (p == 0) begin
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_CTRL,
                         8'hFF, 9'd0, 9'd0, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_CTRL,
                         8'h00, 9'd10, 9'd100, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_MASK,
                         8'hFF, 9'd20, 9'd200, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_ADDR,
                         8'hFF, 9'd250, 9'd0, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_DATA,
                         8'hA5, 9'd250, 9'd1, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_OAM_ADDR,
                         8'hFF, 9'd250, 9'd2, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_OAM_DATA,
                         8'h00, 9'd0, 9'd1, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_OAM_DATA,
                         8'h00, 9'd239, 9'd64, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_OAM_DATA,
                         8'h00, 9'd239, 9'd65, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_OAM_DATA,
                         8'h00, 9'd240, 9'd1, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_STATUS,
                         8'h00, 9'd241, 9'd0, 3'd7, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_STATUS,
                         8'h00, 9'd241, 9'd2, 3'd7, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_STATUS,
                         8'h00, 9'd261, 9'd340, 3'd0, 3'd7);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_SCROLL,
                         8'hFF, 9'd5, 9'd5, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_SCROLL,
                         8'hFF, 9'd5, 9'd6, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR,
                         8'h3F, 9'd5, 9'd7, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR,
                         8'h10, 9'd5, 9'd8, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_DATA,
                         8'h5A, 9'd5, 9'd9, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR,
                         8'h3F, 9'd5, 9'd10, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_ADDR,
                         8'hFF, 9'd5, 9'd11, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_DATA,
                         8'h00, 9'd5, 9'd12, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_DATA,
                         8'h00, 9'd5, 9'd13, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_READ, vucrp_pkg::REG_CTRL,
                         8'h00, 9'd5, 9'd14, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_STATUS,
                         8'hFF, 9'd5, 9'd15, 3'd0, 3'd0);
                queue_at(vucrp_pkg::OP_WRITE, vucrp_pkg::REG_SCROLL,
                         8'h00, 9'd5, 9'd16, 3'd0, 3'd0);
            end
            while (queued_total < (p + 1) * ITEMS_PER_PHASE) begin
                queue_random_burst();
            end
        end

        wait_for_drain();
        repeat (END_CYCLES) @(posedge clk);
        if (mismatches == 0) begin
            $display("Verification passed");
        end else begin
            $display("Verification failed");
        end
        $finish;
    end

endmodule

### filelist.f
rtl/core/vucrp_pkg.sv
rtl/core/vucrp_ram.sv
rtl/core/vucrp_mem.sv
rtl/core/vucrp_core.sv
rtl/core/vucrp_outq.sv
rtl/core/video_unit_cpu_register_port.sv
rtl/core/vucrp_checker.sv
tb/sv/tb_video_unit_cpu_register_port.sv
